### design/itp_pkg.sv
// Shared types, token codes and helpers for the infix to postfix converter.
package itp_pkg;

   // Input token kinds
   localparam logic [1:0] KIND_OPERAND  = 2'd0;
   localparam logic [1:0] KIND_OPERATOR = 2'd1;
   localparam logic [1:0] KIND_END      = 2'd2;

   // Output token kinds
   localparam logic [1:0] OUT_OPERAND  = 2'd0;
   localparam logic [1:0] OUT_OPERATOR = 2'd1;
   localparam logic [1:0] OUT_MARKER   = 2'd2;

   // Operator codes, also the stack entry codes
   localparam logic [2:0] OP_PLUS   = 3'd0;
   localparam logic [2:0] OP_MINUS  = 3'd1;
   localparam logic [2:0] OP_TIMES  = 3'd2;
   localparam logic [2:0] OP_DIVIDE = 3'd3;
   localparam logic [2:0] OP_OPEN   = 3'd4;
   localparam logic [2:0] OP_CLOSE  = 3'd5;

   // Status codes carried by markers
   localparam logic [1:0] STATUS_OK              = 2'd0;
   localparam logic [1:0] STATUS_UNMATCHED_CLOSE = 2'd1;
   localparam logic [1:0] STATUS_UNMATCHED_OPEN  = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW        = 2'd3;

   // Classified command handed from front to back
   typedef enum logic [2:0] {
      CMD_OPERAND,
      CMD_OPER,
      CMD_OPEN,
      CMD_CLOSE,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   code;
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_EVAL,
      BK_FINISH,
      BK_FLUSH
   } back_state_type;

   // High rank for times and divide, low rank for plus and minus
   function automatic logic rank_high(input logic [2:0] code);
      rank_high = (code == OP_TIMES) || (code == OP_DIVIDE);
   endfunction

endpackage

### design/infix_to_postfix_converter_core.sv
// Infix to postfix converter: top level joining front end, queue and back end.
//
// Tokens enter on the req_ channel (valid/ready): operands, operators,
// parentheses and end of expression. Postfix tokens leave on the rsp_ channel,
// each with a status and a last_of_run flag on the final result of a token.
// End produces the remaining operators and a status marker; errors produce a
// marker and empty the stack.
// An operand passes through the queue and is registered in the output register.
// Operands and open parentheses are handled by the back end straight from idle;
// an operator, close or end is accepted, then each stack entry examined is read
// from the stack memory, whose read port is registered, and then decided on. A
// finish state follows when the stack runs empty, and a flush state releases the
// last result. End and close pop one operator for each stack entry examined.
// The front end keeps taking tokens into a two-entry queue while the back end
// works. Reset empties the stack, the queue and the output register. When the
// receiver stalls, the output register holds its transaction, the back end
// waits, the queue fills and req_ready drops.
module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_token_kind,
   input  logic [2:0]             req_op,
   input  logic [VALUE_WIDTH-1:0] req_operand_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_out_kind,
   output logic [1:0]             rsp_out_op,
   output logic [VALUE_WIDTH-1:0] rsp_out_value,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last_of_run
);
   import itp_pkg::*;

   localparam int QW = $bits(cmd_type) + VALUE_WIDTH;

   logic                   enq_valid, enq_ready;
   cmd_type                enq_cmd;
   logic [VALUE_WIDTH-1:0] enq_value;
   logic                   deq_valid, deq_ready;
   logic [QW-1:0]          deq_data;
   cmd_type                deq_cmd;
   logic [VALUE_WIDTH-1:0] deq_value;

   // Classify incoming tokens
   itp_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_token_kind    (req_token_kind),
      .req_op            (req_op),
      .req_operand_value (req_operand_value),
      .enq_valid         (enq_valid),
      .enq_ready         (enq_ready),
      .enq_cmd           (enq_cmd),
      .enq_value         (enq_value)
   );

   // Decouple front and back
   itp_cmd_queue #(
      .DATA_WIDTH(QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (enq_valid),
      .in_ready  (enq_ready),
      .in_data   ({enq_cmd, enq_value}),
      .out_valid (deq_valid),
      .out_ready (deq_ready),
      .out_data  (deq_data)
   );

   assign deq_cmd   = cmd_type'(deq_data[QW-1:VALUE_WIDTH]);
   assign deq_value = deq_data[VALUE_WIDTH-1:0];

   // Execute commands against the operator stack
   itp_back #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (deq_valid),
      .cmd_ready       (deq_ready),
      .cmd             (deq_cmd),
      .cmd_value       (deq_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_op      (rsp_out_op),
      .rsp_out_value   (rsp_out_value),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### design/itp_front.sv
// Front end: accepts input tokens and classifies them into commands.
module itp_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_token_kind,
   input  logic [2:0]             req_op,
   input  logic [VALUE_WIDTH-1:0] req_operand_value,
   output logic                   enq_valid,
   input  logic                   enq_ready,
   output itp_pkg::cmd_type       enq_cmd,
   output logic [VALUE_WIDTH-1:0] enq_value
);
   import itp_pkg::*;

   logic known;

   // Decode the token; unknown kinds and codes are accepted and dropped
   always_comb begin
      known        = 1'b1;
      enq_cmd.kind = CMD_OPERAND;
      enq_cmd.code = req_op[1:0];
      unique case (req_token_kind)
         KIND_OPERAND: enq_cmd.kind = CMD_OPERAND;
         KIND_OPERATOR: begin
            unique case (req_op) inside
               OP_PLUS, OP_MINUS, OP_TIMES, OP_DIVIDE: enq_cmd.kind = CMD_OPER;
               OP_OPEN:  enq_cmd.kind = CMD_OPEN;
               OP_CLOSE: enq_cmd.kind = CMD_CLOSE;
               default:  known = 1'b0;
            endcase
         end
         KIND_END: enq_cmd.kind = CMD_END;
         default:  known = 1'b0;
      endcase
   end

   assign enq_value = req_operand_value;
   assign enq_valid = req_valid && known;
   assign req_ready = enq_ready;

endmodule

### design/itp_cmd_queue.sv
// Two-entry command queue between front and back end.
module itp_cmd_queue #(
   parameter int DATA_WIDTH = 37
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_data
);
   import itp_pkg::*;

   localparam logic [1:0] DEPTH = 2'd2;

   logic [DATA_WIDTH-1:0] slot_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;
   logic                  push, pop;

   assign in_ready  = (fill_ff != DEPTH);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the incoming transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### design/itp_back.sv
// Back end: operator stack sequencer, result hold stage and output register.
module itp_back #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  itp_pkg::cmd_type       cmd,
   input  logic [VALUE_WIDTH-1:0] cmd_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_out_kind,
   output logic [1:0]             rsp_out_op,
   output logic [VALUE_WIDTH-1:0] rsp_out_value,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last_of_run
);
   import itp_pkg::*;

   localparam int CW   = $clog2(STACK_DEPTH + 1);
   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int KEEP = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   localparam logic [VALUE_WIDTH-1:0] VALUE_MASK = {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - KEEP);

   back_state_type        state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   cmd_type               cmd_ff, cmd_in;
   logic [2:0]            stack_mem [STACK_DEPTH];
   logic [2:0]            rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [2:0]            wr_data;
   logic                  full;
   logic                  out_free;

   // Result hold stage: keeps the newest result until its last flag is known
   logic                  hold_valid_ff, hold_valid_in;
   logic [1:0]            hold_kind_ff, hold_kind_in;
   logic [1:0]            hold_op_ff, hold_op_in;
   logic [1:0]            hold_status_ff, hold_status_in;

   // Output register
   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_kind_ff, out_kind_in;
   logic [1:0]            out_op_ff, out_op_in;
   logic [VALUE_WIDTH-1:0] out_value_ff, out_value_in;
   logic [1:0]            out_status_ff, out_status_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_load;

   // Sequencer actions
   logic                  emit_en;
   logic [1:0]            emit_kind, emit_op, emit_status;
   logic                  direct_en;
   logic [1:0]            direct_kind, direct_status;
   logic                  flush_en;

   assign full     = (count_ff == CW'(STACK_DEPTH));
   assign out_free = !out_valid_ff || rsp_ready;
   assign rd_addr  = AW'(count_ff - CW'(1));

   // Next state and stack actions
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      cmd_ready     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = {1'b0, cmd_ff.code};
      emit_en       = 1'b0;
      emit_kind     = OUT_OPERATOR;
      emit_op       = rd_data_ff[1:0];
      emit_status   = STATUS_OK;
      direct_en     = 1'b0;
      direct_kind   = OUT_OPERAND;
      direct_status = STATUS_OK;
      flush_en      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               cmd_in    = cmd;
               case (cmd.kind) inside
                  CMD_OPERAND: direct_en = 1'b1;
                  CMD_OPEN: begin
                     if (full) begin
                        direct_en     = 1'b1;
                        direct_kind   = OUT_MARKER;
                        direct_status = STATUS_OVERFLOW;
                        count_in      = '0;
                     end else begin
                        wr_en    = 1'b1;
                        wr_data  = OP_OPEN;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_OPER, CMD_CLOSE, CMD_END: begin
                     state_in = (count_ff == '0) ? BK_FINISH : BK_READ;
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_READ: state_in = BK_EVAL;
         BK_EVAL: begin
            if (out_free) begin
               case (cmd_ff.kind)
                  CMD_OPER: begin
                     if (rd_data_ff == OP_OPEN ||
                         (!rank_high(rd_data_ff) && rank_high({1'b0, cmd_ff.code}))) begin
                        if (full) begin
                           emit_en     = 1'b1;
                           emit_kind   = OUT_MARKER;
                           emit_op     = 2'd0;
                           emit_status = STATUS_OVERFLOW;
                           count_in    = '0;
                        end else begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CW'(1);
                        end
                        state_in = BK_FLUSH;
                     end else begin
                        emit_en  = 1'b1;
                        count_in = count_ff - CW'(1);
                        state_in = (count_ff == CW'(1)) ? BK_FINISH : BK_READ;
                     end
                  end
                  CMD_CLOSE: begin
                     count_in = count_ff - CW'(1);
                     if (rd_data_ff == OP_OPEN) begin
                        state_in = BK_FLUSH;
                     end else begin
                        emit_en  = 1'b1;
                        state_in = (count_ff == CW'(1)) ? BK_FINISH : BK_READ;
                     end
                  end
                  CMD_END: begin
                     if (rd_data_ff == OP_OPEN) begin
                        emit_en     = 1'b1;
                        emit_kind   = OUT_MARKER;
                        emit_op     = 2'd0;
                        emit_status = STATUS_UNMATCHED_OPEN;
                        count_in    = '0;
                        state_in    = BK_FLUSH;
                     end else begin
                        emit_en  = 1'b1;
                        count_in = count_ff - CW'(1);
                        state_in = (count_ff == CW'(1)) ? BK_FINISH : BK_READ;
                     end
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_FINISH: begin
            // Stack is empty here
            if (out_free) begin
               state_in = BK_FLUSH;
               case (cmd_ff.kind)
                  CMD_OPER: begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  CMD_CLOSE: begin
                     emit_en     = 1'b1;
                     emit_kind   = OUT_MARKER;
                     emit_op     = 2'd0;
                     emit_status = STATUS_UNMATCHED_CLOSE;
                     count_in    = '0;
                  end
                  CMD_END: begin
                     emit_en     = 1'b1;
                     emit_kind   = OUT_MARKER;
                     emit_op     = 2'd0;
                     emit_status = STATUS_OK;
                     count_in    = '0;
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = BK_IDLE;
            end else if (out_free) begin
               flush_en = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Route results through the hold stage, or directly, into the output register
   always_comb begin
      out_load       = direct_en || flush_en || (emit_en && hold_valid_ff);
      hold_valid_in  = hold_valid_ff;
      hold_kind_in   = hold_kind_ff;
      hold_op_in     = hold_op_ff;
      hold_status_in = hold_status_ff;
      if (emit_en) begin
         hold_valid_in  = 1'b1;
         hold_kind_in   = emit_kind;
         hold_op_in     = emit_op;
         hold_status_in = emit_status;
      end else if (flush_en) begin
         hold_valid_in = 1'b0;
      end
      if (direct_en) begin
         out_kind_in   = direct_kind;
         out_op_in     = 2'd0;
         out_value_in  = (direct_kind == OUT_OPERAND) ? (cmd_value & VALUE_MASK) : '0;
         out_status_in = direct_status;
         out_last_in   = 1'b1;
      end else begin
         out_kind_in   = hold_kind_ff;
         out_op_in     = hold_op_ff;
         out_value_in  = '0;
         out_status_in = hold_status_ff;
         out_last_in   = flush_en;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      hold_kind_ff   <= hold_kind_in;
      hold_op_ff     <= hold_op_in;
      hold_status_ff <= hold_status_in;
      if (out_load) begin
         out_kind_ff   <= out_kind_in;
         out_op_ff     <= out_op_in;
         out_value_ff  <= out_value_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

   // Operator stack memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_kind    = out_kind_ff;
   assign rsp_out_op      = out_op_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

### dv/tb_infix_to_postfix_converter_core.sv
// Testbench for the infix to postfix converter core: directed and random token streams.
module tb_infix_to_postfix_converter_core;
   import itp_pkg::*;

   localparam int STACK_DEPTH   = 16;
   localparam int VALUE_WIDTH   = 32;
   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_TOKENS = 45;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 60;

   // Codes the block must ignore
   localparam logic [1:0] KIND_RESERVED  = 2'd3;
   localparam logic [2:0] OP_RESERVED_LO = 3'd6;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;

   typedef struct packed {
      logic [1:0]             kind;
      logic [1:0]             op;
      logic [VALUE_WIDTH-1:0] value;
      logic [1:0]             status;
      logic                   last;
   } postfix_token_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_token_kind;
   logic [2:0]             req_op;
   logic [VALUE_WIDTH-1:0] req_operand_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_out_kind;
   logic [1:0]             rsp_out_op;
   logic [VALUE_WIDTH-1:0] rsp_out_value;
   logic [1:0]             rsp_status;
   logic                   rsp_last_of_run;

   // Shadow operator stack and the postfix tokens still owed by the block
   logic [2:0]        shadow_stack [STACK_DEPTH];
   int                shadow_level;
   postfix_token_type expected_postfix [$];

   int failures;
   int quiet_cycles;
   int tokens_sent;
   int ready_hold;
   bit idling_on;

   infix_to_postfix_converter_core #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_token_kind    (req_token_kind),
      .req_op            (req_op),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_op        (rsp_out_op),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial clock = 1'b0;
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic int op_rank(input logic [2:0] code);
      return (code == OP_TIMES || code == OP_DIVIDE) ? 2 : 1;
   endfunction

   function automatic postfix_token_type make_token(input logic [1:0] kind,
                                                    input logic [1:0] op,
                                                    input logic [VALUE_WIDTH-1:0] value,
                                                    input logic [1:0] status);
      postfix_token_type t;
      t.kind   = kind;
      t.op     = op;
      t.value  = value;
      t.status = status;
      t.last   = 1'b0;
      return t;
   endfunction

   // Run one infix token through the shadow stack and queue the postfix tokens it yields
   function automatic void convert_token(input logic [1:0] kind, input logic [2:0] op,
                                         input logic [VALUE_WIDTH-1:0] value);
      postfix_token_type produced [$];
      logic [1:0]        end_status;
      bit                matched;
      end_status = STATUS_OK;
      matched    = 1'b0;
      case (kind)
         KIND_OPERAND: begin
            produced.push_back(make_token(OUT_OPERAND, '0, value, STATUS_OK));
         end
         KIND_OPERATOR: begin
            // pop operators ranked at or above the incoming one, stopping at an open
            if (op <= OP_DIVIDE) begin
               while (shadow_level > 0 && shadow_stack[shadow_level-1] != OP_OPEN &&
                      op_rank(shadow_stack[shadow_level-1]) >= op_rank(op)) begin
                  shadow_level--;
                  produced.push_back(make_token(OUT_OPERATOR, shadow_stack[shadow_level][1:0],
                                                '0, STATUS_OK));
               end
            end
            if (op <= OP_OPEN) begin
               // push, or flag overflow and clear
               if (shadow_level >= STACK_DEPTH) begin
                  produced.push_back(make_token(OUT_MARKER, '0, '0, STATUS_OVERFLOW));
                  shadow_level = 0;
               end else begin
                  shadow_stack[shadow_level] = op;
                  shadow_level++;
               end
            end else if (op == OP_CLOSE) begin
               // pop down to the matching open and drop it
               while (shadow_level > 0 && !matched) begin
                  shadow_level--;
                  if (shadow_stack[shadow_level] == OP_OPEN) begin
                     matched = 1'b1;
                  end else begin
                     produced.push_back(make_token(OUT_OPERATOR,
                                                   shadow_stack[shadow_level][1:0],
                                                   '0, STATUS_OK));
                  end
               end
               if (!matched) begin
                  produced.push_back(make_token(OUT_MARKER, '0, '0, STATUS_UNMATCHED_CLOSE));
                  shadow_level = 0;
               end
            end
         end
         KIND_END: begin
            // flush operators; a leftover open ends the flush with an error
            while (shadow_level > 0 && end_status == STATUS_OK) begin
               shadow_level--;
               if (shadow_stack[shadow_level] == OP_OPEN) begin
                  end_status = STATUS_UNMATCHED_OPEN;
               end else begin
                  produced.push_back(make_token(OUT_OPERATOR, shadow_stack[shadow_level][1:0],
                                                '0, STATUS_OK));
               end
            end
            produced.push_back(make_token(OUT_MARKER, '0, '0, end_status));
            shadow_level = 0;
         end
         default: begin
         end
      endcase
      if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
      foreach (produced[i]) expected_postfix.push_back(produced[i]);
   endfunction

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (!idling_on || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string what, input postfix_token_type got,
                                  input postfix_token_type want);
      $display({"mismatch %s: got kind=%0d op=%0d value=%h status=%0d last=%0b, ",
                "expected kind=%0d op=%0d value=%h status=%0d last=%0b"},
               what, got.kind, got.op, got.value, got.status, got.last,
               want.kind, want.op, want.value, want.status, want.last);
      failures++;
   endtask

   // Drive one transaction from a falling edge, hold it until taken, then maybe idle
   task automatic send_token(input logic [1:0] kind, input logic [2:0] op,
                             input logic [VALUE_WIDTH-1:0] value);
      int gap;
      req_valid         <= 1'b1;
      req_token_kind    <= kind;
      req_op            <= op;
      req_operand_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      convert_token(kind, op, value);
      if (kind != KIND_RESERVED && !(kind == KIND_OPERATOR && op > OP_CLOSE)) tokens_sent++;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_operand(input logic [VALUE_WIDTH-1:0] value);
      send_token(KIND_OPERAND, 3'($urandom()), value);
   endtask

   task automatic send_operator(input logic [2:0] op);
      send_token(KIND_OPERATOR, op, $urandom());
   endtask

   task automatic send_end();
      send_token(KIND_END, 3'($urandom()), $urandom());
   endtask

   // Hold the sender until every owed postfix token has come out
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_postfix.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Well-formed expression with random operands, operators and nesting
   task automatic send_expression(input int level, input int max_level);
      int terms;
      terms = $urandom_range(1, 3);
      for (int i = 0; i < terms; i++) begin
         if (i > 0) send_operator(3'($urandom_range(OP_PLUS, OP_DIVIDE)));
         if (level < max_level && $urandom_range(1) == 0) begin
            send_operator(OP_OPEN);
            send_expression(level + 1, max_level);
            send_operator(OP_CLOSE);
         end else begin
            send_operand($urandom());
         end
      end
   endtask

   // Operand extremes, plus, times and minus, precedence and left association
   task automatic test_precedence();
      send_operand('0);
      send_operator(OP_PLUS);
      send_operand('1);
      send_operator(OP_TIMES);
      send_operand(32'h0000_0005);
      send_operator(OP_MINUS);
      send_operand(32'h8000_0001);
      send_end();
      wait_for_results();
   endtask

   // Parentheses, with ignored codes in the middle that must not disturb the stack
   task automatic test_parentheses();
      send_operator(OP_OPEN);
      send_operand(32'h1234_5678);
      send_operator(OP_MINUS);
      send_operand(32'h0000_00ff);
      send_token(KIND_RESERVED, OP_CLOSE, $urandom());
      send_operator(OP_RESERVED_LO);
      send_operator(OP_RESERVED_HI);
      send_operator(OP_CLOSE);
      send_operator(OP_DIVIDE);
      send_operand(32'hdead_beef);
      send_end();
      wait_for_results();
   endtask

   // Close with no open left, and end with an open left
   task automatic test_unmatched();
      send_operand(32'h0000_0001);
      send_operator(OP_TIMES);
      send_operand(32'h0000_0002);
      send_operator(OP_DIVIDE);
      send_operand(32'h0000_0003);
      send_operator(OP_PLUS);
      send_operand(32'h0000_0004);
      send_operator(OP_CLOSE);
      send_operator(OP_OPEN);
      send_operand(32'h0000_0005);
      send_operator(OP_MINUS);
      send_end();
      wait_for_results();
   endtask

   // Fill the stack with opens, push once more, then end on the cleared stack
   task automatic test_stack_overflow();
      repeat (STACK_DEPTH + 1) send_operator(OP_OPEN);
      send_end();
      wait_for_results();
   endtask

   // Mostly well-formed expressions, some broken streams and raw noise
   task automatic test_random_tokens();
      int target;
      int roll;
      target = tokens_sent + RANDOM_TOKENS;
      while (tokens_sent < target) begin
         idling_on = ($urandom_range(3) != 0);
         roll = $urandom_range(99);
         if (roll < 75) begin
            send_expression(0, $urandom_range(5));
            send_end();
         end else if (roll < 90) begin
            repeat ($urandom_range(2, 8)) begin
               send_token(2'($urandom_range(KIND_OPERAND, KIND_END)),
                          3'($urandom_range(OP_PLUS, OP_CLOSE)), $urandom());
            end
         end else begin
            send_token(2'($urandom()), 3'($urandom()), $urandom());
         end
         if ($urandom_range(9) == 0) wait_for_results();
      end
   endtask

   // Receiver: random stalls on the result channel
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= pick_gap();
      end
   end

   // Compare each result transaction with the oldest owed token
   always @(posedge clock) begin : check_postfix
      postfix_token_type got;
      postfix_token_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_kind, rsp_out_op, rsp_out_value, rsp_status, rsp_last_of_run};
         if (expected_postfix.size() == 0) begin
            report_mismatch("unexpected result", got, '0);
         end else begin
            want = expected_postfix.pop_front();
            if (got.kind !== want.kind) report_mismatch("out_kind", got, want);
            if (got.op !== want.op) report_mismatch("out_op", got, want);
            if (got.value !== want.value) report_mismatch("out_value", got, want);
            if (got.status !== want.status) report_mismatch("status", got, want);
            if (got.last !== want.last) report_mismatch("last_of_run", got, want);
         end
      end
   end

   // Count cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("tb_infix_to_postfix_converter_core failed");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_token_kind    = KIND_OPERAND;
      req_op            = OP_PLUS;
      req_operand_value = '0;
      rsp_ready         = 1'b0;
      idling_on         = 1'b1;
      shadow_level      = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_precedence();
      test_parentheses();
      test_unmatched();
      test_stack_overflow();
      test_random_tokens();

      // Drain, then leave room for any stray result
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb_infix_to_postfix_converter_core passed");
      end else begin
         $display("tb_infix_to_postfix_converter_core failed");
      end
      $finish;
   end

endmodule
